FILE: rtl/core/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg: shared types and constants of the delimited frame receiver pool
// Command, status and buffer state codes, field widths and frame delimiters.
// ----------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

	localparam int CMD_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int SEL_W    = 4;
	localparam int OFF_W    = 12;
	localparam int STATUS_W = 4;
	localparam int LEN_W    = 13;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'h7E;
	localparam logic [BYTE_W-1:0] END_BYTE   = 8'h0D;

	typedef enum logic [CMD_W-1:0] {
		CMD_BYTE    = 2'd0,
		CMD_READ    = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_IGNORED  = 4'd0,
		ST_STARTED  = 4'd1,
		ST_STORED   = 4'd2,
		ST_COMPLETE = 4'd3,
		ST_NO_FREE  = 4'd4,
		ST_OVERFLOW = 4'd5,
		ST_READ_OK  = 4'd6,
		ST_READ_BAD = 4'd7,
		ST_RELEASE  = 4'd8
	} status_t;

	// Per-buffer state, one-hot.
	typedef enum logic [2:0] {
		SLOT_FREE      = 3'b001,
		SLOT_RECEIVING = 3'b010,
		SLOT_READY     = 3'b100
	} slot_t;

	// Lowest free buffer, as found by the allocator.
	typedef struct packed {
		logic             found;
		logic [SEL_W-1:0] idx;
	} free_pick_t;

endpackage

`default_nettype wire

FILE: rtl/core/dfr_if.sv
// ----------------------------------------------------------------------------
// dfr_if: valid/ready channels of the delimited frame receiver pool
// Command channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfr_in_if;
	logic                       valid;
	logic                       ready;
	logic [dfr_pkg::CMD_W-1:0]  cmd;
	logic [dfr_pkg::BYTE_W-1:0] byte_value;
	logic [dfr_pkg::SEL_W-1:0]  buffer_sel;
	logic [dfr_pkg::OFF_W-1:0]  byte_offset;

	modport source (output valid, cmd, byte_value, buffer_sel, byte_offset, input ready);
	modport sink (input valid, cmd, byte_value, buffer_sel, byte_offset, output ready);
endinterface

interface dfr_out_if;
	logic                         valid;
	logic                         ready;
	logic [dfr_pkg::STATUS_W-1:0] status;
	logic [dfr_pkg::SEL_W-1:0]    buffer_index;
	logic [dfr_pkg::LEN_W-1:0]    frame_length;
	logic [dfr_pkg::BYTE_W-1:0]   data_byte;
	logic                         released;

	modport source (output valid, status, buffer_index, frame_length, data_byte, released,
		input ready);
	modport sink (input valid, status, buffer_index, frame_length, data_byte, released,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dfr_free_pick.sv
// ----------------------------------------------------------------------------
// dfr_free_pick: buffer allocator
// Finds the lowest-numbered free buffer in the pool.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_free_pick #(
	parameter int BUFFERS = 4
) (
	input  wire logic [BUFFERS-1:0] free_mask,
	output dfr_pkg::free_pick_t     pick
);
	import dfr_pkg::*;

	// Scan from the top so the lowest free buffer wins.
	always_comb begin
		pick.found = 1'b0;
		pick.idx   = '0;
		for (int i = BUFFERS - 1; i >= 0; i--) begin
			if (free_mask[i]) begin
				pick.found = 1'b1;
				pick.idx   = SEL_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/delimited_frame_receiver_pool.sv
// ----------------------------------------------------------------------------
// delimited_frame_receiver_pool: frame receiver with a pool of byte buffers
// Assembles 0x7E..0x0D delimited frames into buffers, reads and releases them.
// ----------------------------------------------------------------------------
// Each command beat gives exactly one result beat, via the command register
// and then the result register. One beat enters per clock unless the result
// side stalls, set by the single decision stage and the one write port and
// one registered read port of the frame byte memory (BUFFERS*MAX_LEN bytes).
// A received byte (cmd 0) opens a frame on 0x7E in the lowest free buffer,
// is stored while a frame is open, and closes it on 0x0D; a frame longer
// than MAX_LEN bytes is discarded and its buffer freed. Read (cmd 1) returns
// one stored byte of a ready buffer; release (cmd 2) frees a ready buffer.
// Bytes beyond a frame's length are never returned, so the memory needs no
// clearing after reset. The result side may stall at will: the result
// register holds, and a command beat is still taken while the command stage
// is empty or moving on.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_frame_receiver_pool #(
	parameter int BUFFERS = 4,
	parameter int MAX_LEN = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dfr_in_if.sink     item,
	dfr_out_if.source  result
);
	import dfr_pkg::*;

	localparam int DEPTH = BUFFERS * MAX_LEN;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
	localparam int LW    = $clog2(MAX_LEN + 1);

	// Command stage.
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [SEL_W-1:0]  sel_s1;
	logic [OFF_W-1:0]  off_s1;

	// Result stage.
	logic              valid_s2;
	status_t           status_s2;
	logic [SEL_W-1:0]  idx_s2;
	logic [LW-1:0]     len_s2;
	logic              rd_ok_s2;
	logic              rel_s2;

	// Pool state.
	slot_t             slot_st_q [BUFFERS];
	logic [LW-1:0]     slot_len_q [BUFFERS];
	logic              frame_open_q;
	logic [IW-1:0]     open_slot_q;
	logic [LW-1:0]     open_len_q;  // mirrors slot_len_q of the open buffer

	// Frame byte memory.
	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	logic              adv_s2;
	logic              adv_s1;
	logic [BUFFERS-1:0] free_mask;
	free_pick_t        pick;

	// Decision outputs.
	status_t           status_d;
	logic [SEL_W-1:0]  idx_d;
	logic [LW-1:0]     len_d;
	logic              rd_ok_d;
	logic              rel_d;
	logic              st_we;
	logic [IW-1:0]     st_idx;
	slot_t             st_val;
	logic              len_we;
	logic [IW-1:0]     len_idx;
	logic [LW-1:0]     len_val;
	logic              frame_open_d;
	logic [IW-1:0]     open_slot_d;
	logic [LW-1:0]     open_len_d;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [AW-1:0]     mem_raddr;

	logic              sel_ok;
	logic [IW-1:0]     sel_idx;
	logic [IW-1:0]     pick_idx;
	logic [LW-1:0]     len_inc;

	// Handshake: the result register moves when empty or taken; the command
	// stage moves into it alongside.
	assign adv_s2     = !valid_s2 || result.ready;
	assign adv_s1     = valid_s1 && adv_s2;
	assign item.ready = !valid_s1 || adv_s2;

	always_comb begin
		for (int i = 0; i < BUFFERS; i++) begin
			free_mask[i] = (slot_st_q[i] == SLOT_FREE);
		end
	end

	dfr_free_pick #(
		.BUFFERS(BUFFERS)
	) u_free_pick (
		.free_mask(free_mask),
		.pick(pick)
	);

	assign sel_ok    = 32'(sel_s1) < BUFFERS;
	assign sel_idx   = sel_s1[IW-1:0];
	assign pick_idx  = pick.idx[IW-1:0];
	assign len_inc   = open_len_q + LW'(1);
	assign mem_raddr = AW'(32'(sel_idx) * MAX_LEN + 32'(off_s1));

	// Single-pass decision for the beat in the command stage.
	always_comb begin
		status_d     = ST_IGNORED;
		idx_d        = '0;
		len_d        = '0;
		rd_ok_d      = 1'b0;
		rel_d        = 1'b0;
		st_we        = 1'b0;
		st_idx       = '0;
		st_val       = SLOT_FREE;
		len_we       = 1'b0;
		len_idx      = '0;
		len_val      = '0;
		frame_open_d = frame_open_q;
		open_slot_d  = open_slot_q;
		open_len_d   = open_len_q;
		mem_we       = 1'b0;
		mem_waddr    = AW'(32'(open_slot_q) * MAX_LEN + 32'(open_len_q));

		unique case (cmd_s1)
			CMD_BYTE: begin
				if (!frame_open_q) begin
					if (byte_s1 != START_BYTE) begin
						status_d = ST_IGNORED;
					end else if (pick.found) begin
						// Claim the lowest free buffer; the start byte is byte 0.
						status_d     = ST_STARTED;
						idx_d        = SEL_W'(pick_idx);
						len_d        = LW'(1);
						st_we        = 1'b1;
						st_idx       = pick_idx;
						st_val       = SLOT_RECEIVING;
						len_we       = 1'b1;
						len_idx      = pick_idx;
						len_val      = LW'(1);
						frame_open_d = 1'b1;
						open_slot_d  = pick_idx;
						open_len_d   = LW'(1);
						mem_we       = 1'b1;
						mem_waddr    = AW'(32'(pick_idx) * MAX_LEN);
					end else begin
						status_d = ST_NO_FREE;
					end
				end else if (open_len_q < LW'(MAX_LEN)) begin
					// Append the byte; the end byte also closes the frame.
					idx_d      = SEL_W'(open_slot_q);
					len_d      = len_inc;
					len_we     = 1'b1;
					len_idx    = open_slot_q;
					len_val    = len_inc;
					open_len_d = len_inc;
					mem_we     = 1'b1;
					if (byte_s1 == END_BYTE) begin
						status_d     = ST_COMPLETE;
						st_we        = 1'b1;
						st_idx       = open_slot_q;
						st_val       = SLOT_READY;
						frame_open_d = 1'b0;
					end else begin
						status_d = ST_STORED;
					end
				end else begin
					// Buffer full: drop the frame and free its buffer.
					status_d     = ST_OVERFLOW;
					idx_d        = SEL_W'(open_slot_q);
					len_d        = open_len_q;
					st_we        = 1'b1;
					st_idx       = open_slot_q;
					st_val       = SLOT_FREE;
					frame_open_d = 1'b0;
				end
			end
			CMD_READ: begin
				idx_d    = sel_s1;
				status_d = ST_READ_BAD;
				if (sel_ok) begin
					len_d = slot_len_q[sel_idx];
					if (slot_st_q[sel_idx] == SLOT_READY &&
						LEN_W'(off_s1) < LEN_W'(slot_len_q[sel_idx])) begin
						status_d = ST_READ_OK;
						rd_ok_d  = 1'b1;
					end
				end
			end
			CMD_RELEASE: begin
				idx_d    = sel_s1;
				status_d = ST_RELEASE;
				if (sel_ok) begin
					len_d = slot_len_q[sel_idx];
					if (slot_st_q[sel_idx] == SLOT_READY) begin
						rel_d  = 1'b1;
						st_we  = 1'b1;
						st_idx = sel_idx;
						st_val = SLOT_FREE;
					end
				end
			end
			CMD_NONE: begin
				status_d = ST_IGNORED;
			end
			default: begin
				status_d = ST_IGNORED;
			end
		endcase
	end

	// Command register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1  <= cmd_t'(item.cmd);
			byte_s1 <= item.byte_value;
			sel_s1  <= item.buffer_sel;
			off_s1  <= item.byte_offset;
		end
	end

	// Pool state: advance only when the command beat moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUFFERS; i++) begin
				slot_st_q[i]  <= SLOT_FREE;
				slot_len_q[i] <= '0;
			end
			frame_open_q <= 1'b0;
			open_slot_q  <= '0;
			open_len_q   <= '0;
		end else if (adv_s1) begin
			if (st_we) begin
				slot_st_q[st_idx] <= st_val;
			end
			if (len_we) begin
				slot_len_q[len_idx] <= len_val;
			end
			frame_open_q <= frame_open_d;
			open_slot_q  <= open_slot_d;
			open_len_q   <= open_len_d;
		end
	end

	// Frame memory: one write port, one registered read port. Read data
	// holds while the result waits.
	always_ff @(posedge clk) begin
		if (adv_s1 && mem_we) begin
			mem[mem_waddr] <= byte_s1;
		end
		if (adv_s1 && rd_ok_d) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2 <= status_d;
			idx_s2    <= idx_d;
			len_s2    <= len_d;
			rd_ok_s2  <= rd_ok_d;
			rel_s2    <= rel_d;
		end
	end

	assign result.valid        = valid_s2;
	assign result.status       = status_s2;
	assign result.buffer_index = idx_s2;
	assign result.frame_length = LEN_W'(len_s2);
	assign result.data_byte    = rd_ok_s2 ? rd_data_q : '0;
	assign result.released     = rel_s2;

endmodule

`default_nettype wire

FILE: rtl/core/dfr_checker.sv
// ----------------------------------------------------------------------------
// dfr_checker: port-level checks of the delimited frame receiver pool
// Watches the result channel for handshake and field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         res_valid,
	input wire logic                         res_ready,
	input wire logic [dfr_pkg::STATUS_W-1:0] res_status,
	input wire logic [dfr_pkg::SEL_W-1:0]    res_index,
	input wire logic [dfr_pkg::LEN_W-1:0]    res_length,
	input wire logic [dfr_pkg::BYTE_W-1:0]   res_data,
	input wire logic                         res_released
);
	import dfr_pkg::*;

	// Hold a stalled result beat unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status) &&
		$stable(res_index) && $stable(res_length) && $stable(res_data) &&
		$stable(res_released))
		else $error("result beat changed while stalled");

	// Data comes back only on a successful read.
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != ST_READ_OK |-> res_data == '0)
		else $error("data byte set without a successful read");

	// The released flag is set only on a release result.
	a_rel: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_released |-> res_status == ST_RELEASE)
		else $error("released flag on a non-release result");

	// A new frame holds just its start byte; an ignored or rejected byte names no buffer.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == ST_STARTED) |-> res_length == LEN_W'(1))
		else $error("started frame with length other than one");

	a_nobuf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == ST_IGNORED || res_status == ST_NO_FREE)
		|-> res_index == '0 && res_length == '0)
		else $error("ignored or rejected byte reports a buffer");

endmodule

bind delimited_frame_receiver_pool dfr_checker u_dfr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_status(result.status),
	.res_index(result.buffer_index),
	.res_length(result.frame_length),
	.res_data(result.data_byte),
	.res_released(result.released)
);

`default_nettype wire
